>>> hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

	// Table depth and address width of the heap.
	localparam int MAX_BLOCKS = 64;
	localparam int ADDR_BITS  = 16;

	// Fixed widths of the port fields.
	localparam int SIZE_W      = 16;
	localparam int IDX_FIELD_W = 6;
	localparam int ADR_FIELD_W = 16;
	localparam int LIMIT_W     = 16;
	localparam int HDR_W       = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;

	// Derived widths.
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;
	localparam int WIDE_W = (ADDR_BITS > LIMIT_W) ? ADDR_BITS : LIMIT_W;
	localparam int SUM_W = ((WIDE_W > SIZE_W) ? WIDE_W : SIZE_W) + 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = CFG_IDX_W'(1);

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_ZERO    = 2'd1,
		STAT_NOSPACE = 2'd2,
		STAT_BADFREE = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND,
		S_FREE_CHK
	} state_t;

	// One table entry as stored in the block memory.
	typedef struct packed {
		logic                 free;
		logic [SIZE_W-1:0]    size;
		logic [ADDR_BITS-1:0] start;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Configuration registers handed to the sequencer.
	typedef struct packed {
		logic [LIMIT_W-1:0] heap_limit;
		logic [HDR_W-1:0]   header_bytes;
	} cfg_t;

endpackage

>>> hw/rtl/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// request   start, busy            operation, request_size, block_index
// result    done (one cycle)       status, granted_index, payload_address
// config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A zero-size allocate or an out-of-range free answers in the cycle after start;
// a free reads its entry back first. An allocate reads the block table memory
// one entry per cycle in address order, then appends a block if none fits.
// Reset clears the entry count and heap top and loads the register defaults;
// table entries are written before they are ever read, so the memory needs no
// clearing pass.
// The result strobe lasts one cycle and cannot be held off.

module first_fit_block_allocator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic [ffba_pkg::SIZE_W-1:0]          request_size,
	input  logic [ffba_pkg::IDX_FIELD_W-1:0]     block_index,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [ffba_pkg::IDX_FIELD_W-1:0]     granted_index,
	output logic [ffba_pkg::ADR_FIELD_W-1:0]     payload_address,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ffba_pkg::CFG_DATA_W-1:0]      cfg_data
);

	ffba_pkg::cfg_t cfg_q;

	logic                          rd_en, wr_en;
	logic [ffba_pkg::IDX_W-1:0]    rd_addr, wr_addr;
	logic [ffba_pkg::ENTRY_W-1:0]  rd_data, wr_data;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_limit   <= ffba_pkg::LIMIT_W'(65535);
			cfg_q.header_bytes <= ffba_pkg::HDR_W'(40);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffba_pkg::REG_HEAP_LIMIT: begin
					cfg_q.heap_limit <= ffba_pkg::LIMIT_W'(cfg_data);
				end
				ffba_pkg::REG_HEADER_BYTES: begin
					cfg_q.header_bytes <= ffba_pkg::HDR_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer: scan, append and free.
	ffba_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.start           (start),
		.operation       (operation),
		.request_size    (request_size),
		.block_index     (block_index),
		.busy            (busy),
		.done            (done),
		.status          (status),
		.granted_index   (granted_index),
		.payload_address (payload_address),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data)
	);

	// Block table: start address, size and free mark of every entry.
	ffba_ram #(
		.WIDTH (ffba_pkg::ENTRY_W),
		.DEPTH (ffba_pkg::MAX_BLOCKS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

>>> hw/rtl/ffba_ram.sv
`timescale 1ns / 1ps

module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/ffba_engine.sv
`timescale 1ns / 1ps

module ffba_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ffba_pkg::cfg_t                       cfg,
	input  logic                                 start,
	input  logic                                 operation,
	input  logic [ffba_pkg::SIZE_W-1:0]          request_size,
	input  logic [ffba_pkg::IDX_FIELD_W-1:0]     block_index,
	output logic                                 busy,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [ffba_pkg::IDX_FIELD_W-1:0]     granted_index,
	output logic [ffba_pkg::ADR_FIELD_W-1:0]     payload_address,
	output logic                                 rd_en,
	output logic [ffba_pkg::IDX_W-1:0]           rd_addr,
	input  logic [ffba_pkg::ENTRY_W-1:0]         rd_data,
	output logic                                 wr_en,
	output logic [ffba_pkg::IDX_W-1:0]           wr_addr,
	output logic [ffba_pkg::ENTRY_W-1:0]         wr_data
);

	localparam int IDX_W = ffba_pkg::IDX_W;
	localparam int CNT_W = ffba_pkg::CNT_W;
	localparam int CMP_W = ffba_pkg::CMP_W;
	localparam int SUM_W = ffba_pkg::SUM_W;

	ffba_pkg::state_t  state_q, n_state;
	ffba_pkg::status_t status_q, n_status;
	ffba_pkg::entry_t  rd_entry, wr_entry;

	logic [CNT_W-1:0]                 count_q, n_count;
	logic [ffba_pkg::ADDR_BITS-1:0]   top_q, n_top;
	logic [ffba_pkg::SIZE_W-1:0]      size_q, n_size;
	logic [IDX_W-1:0]                 idx_q, n_idx;
	logic                             done_q, n_done;
	logic [ffba_pkg::IDX_FIELD_W-1:0] gidx_q, n_gidx;
	logic [ffba_pkg::ADR_FIELD_W-1:0] paddr_q, n_paddr;

	logic [SUM_W-1:0] payload, new_top;
	logic             append_fail;
	logic             free_ok;
	logic             scan_hit;
	logic             scan_last;

	assign rd_entry = ffba_pkg::entry_t'(rd_data);
	assign wr_data  = wr_entry;

	// Append arithmetic: header goes at the heap top, payload after it.
	assign payload = SUM_W'(top_q) + SUM_W'(cfg.header_bytes);
	assign new_top = payload + SUM_W'(size_q);
	assign append_fail = (count_q == CNT_W'(ffba_pkg::MAX_BLOCKS)) ||
		(new_top > SUM_W'(cfg.heap_limit)) ||
		(new_top > SUM_W'({ffba_pkg::ADDR_BITS{1'b1}}));

	assign free_ok   = CMP_W'(block_index) < CMP_W'(count_q);
	assign scan_hit  = rd_entry.free && (rd_entry.size >= size_q);
	assign scan_last = (CNT_W'(idx_q) + CNT_W'(1)) >= count_q;

	// State and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
			count_q <= '0;
			top_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= n_state;
			count_q <= n_count;
			top_q   <= n_top;
			done_q  <= n_done;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		size_q   <= n_size;
		idx_q    <= n_idx;
		status_q <= n_status;
		gidx_q   <= n_gidx;
		paddr_q  <= n_paddr;
	end

	// Next state, memory accesses and result. A write lands at the edge that
	// raises the result strobe, and the next beat reads in the cycle after that
	// edge at the earliest, so no forwarding is needed.
	always_comb begin
		n_state  = state_q;
		n_count  = count_q;
		n_top    = top_q;
		n_size   = size_q;
		n_idx    = idx_q;
		n_done   = 1'b0;
		n_status = status_q;
		n_gidx   = gidx_q;
		n_paddr  = paddr_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_entry = rd_entry;

		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (start) begin
					n_size = request_size;
					n_gidx = '0;
					n_paddr = '0;
					if (operation) begin
						if (free_ok) begin
							n_idx   = IDX_W'(block_index);
							rd_en   = 1'b1;
							rd_addr = IDX_W'(block_index);
							n_state = ffba_pkg::S_FREE_CHK;
						end else begin
							n_done   = 1'b1;
							n_status = ffba_pkg::STAT_BADFREE;
						end
					end else if (request_size == '0) begin
						n_done   = 1'b1;
						n_status = ffba_pkg::STAT_ZERO;
					end else if (count_q == '0) begin
						n_state = ffba_pkg::S_APPEND;
					end else begin
						n_idx   = '0;
						rd_en   = 1'b1;
						rd_addr = '0;
						n_state = ffba_pkg::S_SCAN;
					end
				end
			end

			// One entry is checked each cycle, in address order.
			ffba_pkg::S_SCAN: begin
				if (scan_hit) begin
					wr_en         = 1'b1;
					wr_entry.free = 1'b0;
					n_done        = 1'b1;
					n_status      = ffba_pkg::STAT_OK;
					n_gidx        = ffba_pkg::IDX_FIELD_W'(idx_q);
					n_paddr       = ffba_pkg::ADR_FIELD_W'(rd_entry.start);
					n_state       = ffba_pkg::S_IDLE;
				end else if (scan_last) begin
					n_state = ffba_pkg::S_APPEND;
				end else begin
					n_idx   = idx_q + IDX_W'(1);
					rd_en   = 1'b1;
					rd_addr = idx_q + IDX_W'(1);
				end
			end

			// No free entry fits: add a new block at the heap top, or report no space.
			ffba_pkg::S_APPEND: begin
				n_done  = 1'b1;
				n_state = ffba_pkg::S_IDLE;
				if (append_fail) begin
					n_status = ffba_pkg::STAT_NOSPACE;
				end else begin
					wr_en          = 1'b1;
					wr_addr        = IDX_W'(count_q);
					wr_entry.free  = 1'b0;
					wr_entry.size  = size_q;
					wr_entry.start = ffba_pkg::ADDR_BITS'(payload);
					n_count        = count_q + CNT_W'(1);
					n_top          = ffba_pkg::ADDR_BITS'(new_top);
					n_status       = ffba_pkg::STAT_OK;
					n_gidx         = ffba_pkg::IDX_FIELD_W'(count_q);
					n_paddr        = ffba_pkg::ADR_FIELD_W'(payload);
				end
			end

			// Entry read back: refuse a double free, else mark it free.
			ffba_pkg::S_FREE_CHK: begin
				n_done  = 1'b1;
				n_state = ffba_pkg::S_IDLE;
				if (rd_entry.free) begin
					n_status = ffba_pkg::STAT_BADFREE;
				end else begin
					wr_en         = 1'b1;
					wr_entry.free = 1'b1;
					n_status      = ffba_pkg::STAT_OK;
				end
			end

			default: begin
				n_state = ffba_pkg::S_IDLE;
			end
		endcase
	end

	assign busy            = (state_q != ffba_pkg::S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign granted_index   = gidx_q;
	assign payload_address = paddr_q;

endmodule
